>>> src/bpd_pkg.sv
// Shared types, constants and arithmetic helpers for the body pose difference pipeline.
package bpd_pkg;

  localparam int VEC_BITS   = 21;
  localparam int QUAT_BITS  = 16;
  localparam int CORDIC_N   = 27;
  localparam int ISQ_STEPS  = 32;
  localparam int NCELL      = 32;
  localparam logic [15:0] ANGLE_MAX = 16'd46080;
  localparam logic [21:0] DIST_MAX  = 22'h3FFFFF;

  typedef enum logic [2:0] {
    KIND_EQUAL   = 3'd0,
    KIND_CHANGED = 3'd1,
    KIND_ONLY_A  = 3'd2,
    KIND_ONLY_B  = 3'd3,
    KIND_NONE    = 3'd4
  } kind_t;

  typedef struct packed {
    logic [63:0] body_id;
    logic [1:0]  flags_a;
    logic [1:0]  flags_b;
    logic [62:0] pos_a;
    logic [62:0] pos_b;
    logic [62:0] linvel_a;
    logic [62:0] linvel_b;
    logic [62:0] angvel_a;
    logic [62:0] angvel_b;
    logic [63:0] quat_a;
    logic [63:0] quat_b;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] result_id;
    logic [2:0]  change_kind;
    logic [21:0] position_distance;
    logic [21:0] height_delta;
    logic [21:0] vertical_speed_delta;
    logic [21:0] velocity_distance;
    logic [15:0] angle_degrees;
    logic        sleep_changed;
  } out_beat_t;

  typedef struct packed {
    logic [63:0] val;
    logic [63:0] rem;
    logic [31:0] root;
  } isq_t;

  typedef struct packed {
    logic [63:0] body_id;
    kind_t       kind;
    logic        both;
    logic        any_diff;
    logic        sleep_chg;
    logic        quat_zero;
    logic        s2_zero;
    logic [21:0] hd;
    logic [21:0] vd;
    isq_t        sp;
    isq_t        sv;
    isq_t        s2;
    logic [63:0] c;
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    logic signed [31:0] z;
  } cell_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0: atan_lut = 32'd47185920;  5'd1: atan_lut = 32'd27855475;
      5'd2: atan_lut = 32'd14718068;  5'd3: atan_lut = 32'd7471121;
      5'd4: atan_lut = 32'd3750058;   5'd5: atan_lut = 32'd1876857;
      5'd6: atan_lut = 32'd938658;    5'd7: atan_lut = 32'd469357;
      5'd8: atan_lut = 32'd234682;    5'd9: atan_lut = 32'd117342;
      5'd10: atan_lut = 32'd58671;    5'd11: atan_lut = 32'd29335;
      5'd12: atan_lut = 32'd14668;    5'd13: atan_lut = 32'd7334;
      5'd14: atan_lut = 32'd3667;     5'd15: atan_lut = 32'd1833;
      5'd16: atan_lut = 32'd917;      5'd17: atan_lut = 32'd458;
      5'd18: atan_lut = 32'd229;      5'd19: atan_lut = 32'd115;
      5'd20: atan_lut = 32'd57;       5'd21: atan_lut = 32'd29;
      5'd22: atan_lut = 32'd14;       5'd23: atan_lut = 32'd7;
      5'd24: atan_lut = 32'd4;        5'd25: atan_lut = 32'd2;
      5'd26: atan_lut = 32'd1;
      default: atan_lut = 32'd0;
    endcase
  endfunction

  function automatic logic [6:0] lead_zeros(input logic [63:0] v);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(63 - i);
    end
    return n;
  endfunction

  function automatic isq_t isq_step(input isq_t s);
    isq_t o;
    logic [65:0] trial;
    logic [65:0] rem2;
    o = s;
    rem2 = {s.rem, s.val[63:62]};
    trial = {32'd0, s.root, 2'b01};
    o.val = {s.val[61:0], 2'b00};
    if (rem2 >= trial) begin
      o.rem = 64'(rem2 - trial);
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem = rem2[63:0];
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [21:0] dist_sat(input isq_t s);
    logic [32:0] r;
    r = {1'b0, s.root} + {32'd0, (s.rem > {32'd0, s.root})};
    return (r > {11'd0, DIST_MAX}) ? DIST_MAX : r[21:0];
  endfunction

endpackage

>>> src/bpd_front.sv
// Front stages: unpack the sides, form differences, squares and quaternion products; normalize s2 and c.
module bpd_front (
  input  logic              clk,
  input  logic              en,
  input  bpd_pkg::in_beat_t d,
  output bpd_pkg::cell_t    q
);
  import bpd_pkg::*;

  logic signed [VEC_BITS:0] dp [3];
  logic signed [VEC_BITS:0] dv [3];
  logic signed [QUAT_BITS-1:0] a [4];
  logic signed [QUAT_BITS-1:0] b [4];
  logic signed [63:0] dp1_r, dv1_r;
  logic [45:0] sqp [3];
  logic [45:0] sqv [3];
  logic signed [32:0] prod [4];
  logic signed [32:0] crs [6];
  logic [31:0] qa2 [4];
  logic [31:0] qb2 [4];
  logic [63:0] body_r;
  logic [1:0] fa_r, fb_r;
  logic vel_r, pos_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dp[i] = (VEC_BITS+1)'(signed'(d.pos_b[i*VEC_BITS +: VEC_BITS]))
            - (VEC_BITS+1)'(signed'(d.pos_a[i*VEC_BITS +: VEC_BITS]));
      dv[i] = (VEC_BITS+1)'(signed'(d.linvel_b[i*VEC_BITS +: VEC_BITS]))
            - (VEC_BITS+1)'(signed'(d.linvel_a[i*VEC_BITS +: VEC_BITS]));
    end
    for (int i = 0; i < 4; i++) begin
      a[i] = signed'(d.quat_a[i*QUAT_BITS +: QUAT_BITS]);
      b[i] = signed'(d.quat_b[i*QUAT_BITS +: QUAT_BITS]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      body_r <= d.body_id;
      fa_r <= d.flags_a;
      fb_r <= d.flags_b;
      dp1_r <= 64'(dp[1]);
      dv1_r <= 64'(dv[1]);
      pos_r <= (dp[0] != 0) || (dp[1] != 0) || (dp[2] != 0);
      vel_r <= (dv[0] != 0) || (dv[1] != 0) || (dv[2] != 0) ||
               (d.angvel_a[3*VEC_BITS-1:0] != d.angvel_b[3*VEC_BITS-1:0]);
      for (int i = 0; i < 3; i++) begin
        sqp[i] <= 46'(dp[i] * dp[i]);
        sqv[i] <= 46'(dv[i] * dv[i]);
      end
      for (int i = 0; i < 4; i++) begin
        prod[i] <= 33'(a[i] * b[i]);
        qa2[i] <= 32'(a[i] * a[i]);
        qb2[i] <= 32'(b[i] * b[i]);
      end
      crs[0] <= 33'(a[0]*b[1]) - 33'(a[1]*b[0]);
      crs[1] <= 33'(a[0]*b[2]) - 33'(a[2]*b[0]);
      crs[2] <= 33'(a[0]*b[3]) - 33'(a[3]*b[0]);
      crs[3] <= 33'(a[1]*b[2]) - 33'(a[2]*b[1]);
      crs[4] <= 33'(a[1]*b[3]) - 33'(a[3]*b[1]);
      crs[5] <= 33'(a[2]*b[3]) - 33'(a[3]*b[2]);
    end
  end

  logic [63:0] crsq [6];
  logic signed [63:0] dot;
  logic [63:0] s2;
  logic [63:0] c_abs;
  cell_t pn;
  cell_t p;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      crsq[i] = 64'(crs[i] * crs[i]);
    end
    dot = 64'(prod[0]) + 64'(prod[1]) + 64'(prod[2]) + 64'(prod[3]);
    s2 = crsq[0] + crsq[1] + crsq[2] + crsq[3] + crsq[4] + crsq[5];
    c_abs = dot[63] ? 64'(-dot) : 64'(dot);
    pn.body_id = (fa_r[0] | fb_r[0]) ? body_r : 64'd0;
    pn.kind = (fa_r[0] && fb_r[0]) ? KIND_EQUAL : fa_r[0] ? KIND_ONLY_A :
              fb_r[0] ? KIND_ONLY_B : KIND_NONE;
    pn.both = fa_r[0] && fb_r[0];
    pn.any_diff = pos_r || vel_r || (fa_r[1] != fb_r[1]);
    pn.sleep_chg = fa_r[1] != fb_r[1];
    pn.quat_zero = ((qa2[0]|qa2[1]|qa2[2]|qa2[3]) == 0) ||
                   ((qb2[0]|qb2[1]|qb2[2]|qb2[3]) == 0);
    pn.s2_zero = s2 == 0;
    pn.hd = (dp1_r > 64'sd2097151) ? 22'h1FFFFF :
            (dp1_r < -64'sd2097152) ? 22'h200000 : dp1_r[21:0];
    pn.vd = (dv1_r > 64'sd2097151) ? 22'h1FFFFF :
            (dv1_r < -64'sd2097152) ? 22'h200000 : dv1_r[21:0];
    pn.sp.val = 64'(sqp[0]) + 64'(sqp[1]) + 64'(sqp[2]);
    pn.sp.rem = 64'd0;
    pn.sp.root = 32'd0;
    pn.sv.val = 64'(sqv[0]) + 64'(sqv[1]) + 64'(sqv[2]);
    pn.sv.rem = 64'd0;
    pn.sv.root = 32'd0;
    pn.s2.val = s2;
    pn.s2.rem = 64'd0;
    pn.s2.root = 32'd0;
    pn.c = c_abs;
    pn.xs = 64'sd0;
    pn.ys = 64'sd0;
    pn.z = 32'sd0;
  end

  always_ff @(posedge clk) begin
    if (en) p <= pn;
  end

  logic [6:0] lz_s, lz_c, n_s, n_c, nsh;
  cell_t qn;

  always_comb begin
    lz_s = lead_zeros(p.s2.val);
    lz_c = lead_zeros(p.c);
    n_s = (lz_s > 7'd3) ? 7'((lz_s - 7'd2) >> 1) : 7'd0;
    n_c = (lz_c > 7'd34) ? 7'(lz_c - 7'd34) : 7'd0;
    nsh = (n_s < n_c) ? n_s : n_c;
    qn = p;
    qn.s2.val = p.s2.val << {nsh[5:0], 1'b0};
    qn.c = p.c << nsh;
  end

  always_ff @(posedge clk) begin
    if (en) q <= qn;
  end
endmodule

>>> src/bpd_cell.sv
// One cell of the chain: a square-root digit step or, past the root cells, a CORDIC rotation step.
module bpd_cell (
  input  logic           clk,
  input  logic           en,
  input  logic [5:0]     idx,
  input  bpd_pkg::cell_t d,
  output bpd_pkg::cell_t q
);
  import bpd_pkg::*;

  cell_t n;
  logic [4:0] ci;
  logic signed [63:0] ex, dy;

  always_comb begin
    n = d;
    ci = 5'(idx - 6'(ISQ_STEPS));
    ex = 64'sd0;
    dy = 64'sd0;
    if (idx < 6'(ISQ_STEPS)) begin
      n.sp = isq_step(d.sp);
      n.sv = isq_step(d.sv);
      n.s2 = isq_step(d.s2);
    end else begin
      ex = $signed(64'($unsigned(d.xs) >> ci));
      if (d.ys >= 0) begin
        dy = $signed(64'($unsigned(d.ys) >> ci));
        n.xs = d.xs + dy;
        n.ys = d.ys - ex;
        n.z = d.z + $signed(atan_lut(ci));
      end else begin
        dy = $signed(64'($unsigned(-d.ys) >> ci));
        n.xs = d.xs + dy;
        n.ys = d.ys + ex;
        n.z = d.z - $signed(atan_lut(ci));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= n;
  end
endmodule

>>> src/bpd_back.sv
// Stage between chains: normalize the CORDIC inputs; final stage: form the result.
module bpd_back (
  input  logic            clk,
  input  logic            en,
  input  bpd_pkg::cell_t  d_norm,
  output bpd_pkg::cell_t  q_norm,
  input  bpd_pkg::cell_t  d_fin,
  output bpd_pkg::out_beat_t q_fin
);
  import bpd_pkg::*;

  logic [63:0] x, y;
  logic [6:0] lz;
  logic [6:0] nsh;
  logic [31:0] zc;
  logic [21:0] qang;
  logic [15:0] ang;
  cell_t nrm;
  out_beat_t fin;

  always_comb begin
    lz = lead_zeros(d_norm.c | 64'(d_norm.s2.root));
    nsh = (lz > 7'd5) ? 7'(lz - 7'd5) : 7'd0;
    x = d_norm.c << nsh;
    y = 64'(d_norm.s2.root) << nsh;
    nrm = d_norm;
    nrm.xs = $signed(x);
    nrm.ys = $signed(y);
    nrm.z = 32'sd0;
    zc = d_fin.z[31] ? 32'd0 : d_fin.z;
    qang = 22'((33'(zc) + 33'd1024) >> 11);
    if (d_fin.quat_zero) ang = ANGLE_MAX;
    else if (d_fin.s2_zero) ang = 16'd0;
    else ang = (qang > 22'(ANGLE_MAX)) ? ANGLE_MAX : qang[15:0];
    fin.result_id = d_fin.body_id;
    if (!d_fin.both) begin
      fin.change_kind = d_fin.kind;
      fin.position_distance = '0;
      fin.height_delta = '0;
      fin.vertical_speed_delta = '0;
      fin.velocity_distance = '0;
      fin.angle_degrees = '0;
      fin.sleep_changed = 1'b0;
    end else begin
      fin.change_kind = (d_fin.any_diff || ang != 0) ? KIND_CHANGED : KIND_EQUAL;
      fin.position_distance = dist_sat(d_fin.sp);
      fin.height_delta = d_fin.hd;
      fin.vertical_speed_delta = d_fin.vd;
      fin.velocity_distance = dist_sat(d_fin.sv);
      fin.angle_degrees = ang;
      fin.sleep_changed = d_fin.sleep_chg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_norm <= nrm;
      q_fin <= fin;
    end
  end
endmodule

>>> src/body_pose_difference.sv
// Top level of the body pose difference pipeline.
//  channel | direction | handshake
//  in      | input     | in_valid / in_stall
//  out     | output    | out_valid / out_stall
// One beat per cycle unless the output stalls; the pipeline holds three front
// stages, 32 root digit cells, one normalize stage, 27 CORDIC cells, one result stage.
// Reset clears the valid bits of every stage.
// A stall on a valid output beat freezes the whole chain and raises in_stall.
module body_pose_difference (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bpd_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bpd_pkg::out_beat_t  out_data
);
  import bpd_pkg::*;

  localparam int DEPTH = 3 + ISQ_STEPS + 1 + CORDIC_N + 1;

  logic en;
  logic [DEPTH-1:0] vld;
  cell_t f_q;
  cell_t chain [ISQ_STEPS + CORDIC_N + 2];

  assign en = !(out_stall && out_valid);
  assign in_stall = !en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[DEPTH-2:0], in_valid};
  end

  bpd_front u_front (.clk(clk), .en(en), .d(in_data), .q(f_q));
  assign chain[0] = f_q;

  for (genvar g = 0; g < ISQ_STEPS; g++) begin : g_root
    bpd_cell u_cell (.clk(clk), .en(en), .idx(6'(g)), .d(chain[g]), .q(chain[g+1]));
  end

  for (genvar g = 0; g < CORDIC_N; g++) begin : g_cordic
    bpd_cell u_cell (.clk(clk), .en(en), .idx(6'(ISQ_STEPS + g)),
                     .d(chain[ISQ_STEPS+1+g]), .q(chain[ISQ_STEPS+2+g]));
  end

  bpd_back u_back (.clk(clk), .en(en), .d_norm(chain[ISQ_STEPS]),
                   .q_norm(chain[ISQ_STEPS+1]),
                   .d_fin(chain[ISQ_STEPS+CORDIC_N+1]), .q_fin(out_data));
endmodule

>>> src/bpd_checker.sv
// Port-level checks for the body pose difference block, bound to the top level.
module bpd_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input bpd_pkg::out_beat_t out_data
);
  import bpd_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat dropped under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid)
    else $error("input beat withdrawn under stall");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");
  a_angle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.angle_degrees <= ANGLE_MAX)
    else $error("angle out of range");
endmodule

bind body_pose_difference bpd_checker u_bpd_checker (.*);

>>> bench/tb_top.sv
// Self-checking bench for the body pose difference pipeline: directed table, then random beats.
`timescale 1ns / 100ps

module tb_top;
  import bpd_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 130;

  typedef struct {
    in_beat_t  d;
    bit        typed;
    out_beat_t e;
  } row_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;

  out_beat_t pending_diffs[$];
  row_t      rows[$];
  int        send_idle;
  int        recv_idle;
  int        errors;
  int        cycles;
  bit        use_typed;
  out_beat_t typed_exp;
  bit        hold_req;
  bit        hold_seen;
  int        hold_left;

  body_pose_difference dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint comp(logic [63:0] p, int idx, int bits);
    logic [63:0] v;
    v = (p >> (idx * bits)) & ((64'd1 << bits) - 64'd1);
    if (v[bits-1]) return longint'(v) - longint'(64'd1 << bits);
    return longint'(v);
  endfunction

  function automatic logic [63:0] sq_mag(longint v);
    logic [63:0] m;
    m = (v < 0) ? 64'd0 - 64'(v) : 64'(v);
    return m * m;
  endfunction

  function automatic logic [63:0] root_of(logic [63:0] v, output logic [63:0] rem);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    rem = v;
    return r;
  endfunction

  function automatic logic [21:0] distance(logic [63:0] sumsq);
    logic [63:0] rem;
    logic [63:0] r;
    r = root_of(sumsq, rem);
    if (rem > r) r = r + 1;
    return (r > 64'(DIST_MAX)) ? DIST_MAX : r[21:0];
  endfunction

  function automatic logic [21:0] clamp22(longint v);
    if (v > 2097151) v = 2097151;
    if (v < -2097152) v = -2097152;
    return v[21:0];
  endfunction

  function automatic logic [31:0] atan_step(int i);
    logic [31:0] t[27];
    t = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
          469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833, 917,
          458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
    return t[i];
  endfunction

  function automatic longint half_atan(logic [63:0] x, logic [63:0] y);
    longint xs;
    longint ys;
    longint z;
    logic [63:0] ex;
    logic [63:0] dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    while (x < (64'd1 << 58) && y < (64'd1 << 58)) begin
      x = x << 1;
      y = y << 1;
    end
    xs = longint'(x);
    ys = longint'(y);
    for (int i = 0; i < 27; i++) begin
      ex = 64'(xs) >> i;
      if (ys >= 0) begin
        dy = 64'(ys) >> i;
        xs = xs + longint'(dy);
        ys = ys - longint'(ex);
        z = z + longint'(atan_step(i));
      end else begin
        dy = (64'd0 - 64'(ys)) >> i;
        xs = xs + longint'(dy);
        ys = ys + longint'(ex);
        z = z - longint'(atan_step(i));
      end
    end
    return z;
  endfunction

  function automatic logic [15:0] rotation(logic [63:0] qa, logic [63:0] qb);
    longint a[4];
    longint b[4];
    longint dot;
    logic [63:0] aa;
    logic [63:0] bb;
    logic [63:0] c;
    logic [63:0] s2;
    logic [63:0] s;
    logic [63:0] rem;
    logic [63:0] q;
    longint z;
    dot = 0; aa = 0; bb = 0; s2 = 0;
    for (int i = 0; i < 4; i++) begin
      a[i] = comp(qa, i, QUAT_BITS);
      b[i] = comp(qb, i, QUAT_BITS);
      dot = dot + a[i] * b[i];
      aa = aa + sq_mag(a[i]);
      bb = bb + sq_mag(b[i]);
    end
    if (aa == 0 || bb == 0) return ANGLE_MAX;
    c = (dot < 0) ? 64'd0 - 64'(dot) : 64'(dot);
    for (int i = 0; i < 4; i++)
      for (int j = i + 1; j < 4; j++)
        s2 = s2 + sq_mag(a[i] * b[j] - a[j] * b[i]);
    if (s2 == 0) return 0;
    while ((s2 >> 60) == 0 && (c >> 29) == 0) begin
      s2 = s2 << 2;
      c = c << 1;
    end
    s = root_of(s2, rem);
    z = half_atan(c, s);
    if (z < 0) z = 0;
    q = (64'(z) + 64'd1024) >> 11;
    return (q > 64'(ANGLE_MAX)) ? ANGLE_MAX : q[15:0];
  endfunction

  function automatic out_beat_t pose_diff(in_beat_t d);
    out_beat_t o;
    longint dp[3];
    longint dv[3];
    logic [63:0] sp;
    logic [63:0] sv;
    bit moved;
    bit sleep;
    o = '0;
    sp = 0; sv = 0; moved = 0;
    o.result_id = (d.flags_a[0] || d.flags_b[0]) ? d.body_id : 64'd0;
    if (!d.flags_a[0] || !d.flags_b[0]) begin
      o.change_kind = d.flags_a[0] ? KIND_ONLY_A : d.flags_b[0] ? KIND_ONLY_B : KIND_NONE;
      return o;
    end
    for (int i = 0; i < 3; i++) begin
      dp[i] = comp(d.pos_b, i, VEC_BITS) - comp(d.pos_a, i, VEC_BITS);
      dv[i] = comp(d.linvel_b, i, VEC_BITS) - comp(d.linvel_a, i, VEC_BITS);
      sp = sp + sq_mag(dp[i]);
      sv = sv + sq_mag(dv[i]);
      if (dv[i] != 0 || comp(d.angvel_a, i, VEC_BITS) != comp(d.angvel_b, i, VEC_BITS))
        moved = 1;
    end
    sleep = d.flags_a[1] ^ d.flags_b[1];
    o.position_distance    = distance(sp);
    o.height_delta         = clamp22(dp[1]);
    o.vertical_speed_delta = clamp22(dv[1]);
    o.velocity_distance    = distance(sv);
    o.angle_degrees        = rotation(d.quat_a, d.quat_b);
    o.sleep_changed        = sleep;
    o.change_kind = (sp != 0 || o.angle_degrees != 0 || sleep || moved) ?
                    KIND_CHANGED : KIND_EQUAL;
    return o;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [62:0] vec3(longint x, longint y, longint z);
    return {z[20:0], y[20:0], x[20:0]};
  endfunction

  function automatic logic [62:0] near_vec(logic [62:0] base);
    case ($urandom_range(3))
      0: return base;
      1: return base ^ (63'($urandom_range(15)) << (21 * $urandom_range(2)));
      2: return base ^ (63'd1 << $urandom_range(62));
      default: return 63'(rnd64());
    endcase
  endfunction

  function automatic logic [63:0] near_quat(logic [63:0] base);
    logic [63:0] n;
    case ($urandom_range(6))
      0: return base;
      1: begin
        for (int i = 0; i < 4; i++) n[16*i +: 16] = 16'd0 - base[16*i +: 16];
        return n;
      end
      2: return base ^ 64'($urandom_range(3));
      3: return base ^ (64'd1 << $urandom_range(63));
      4: return ($urandom_range(3) == 0) ? 64'd0 : {48'd0, 16'h4000};
      default: return rnd64();
    endcase
  endfunction

  function automatic in_beat_t random_beat();
    in_beat_t d;
    d.body_id = rnd64();
    if ($urandom_range(9) < 7) begin
      d.flags_a = {1'($urandom), 1'b1};
      d.flags_b = {($urandom_range(3) == 0) ? ~d.flags_a[1] : d.flags_a[1], 1'b1};
    end else begin
      d.flags_a = 2'($urandom);
      d.flags_b = 2'($urandom);
    end
    d.pos_a    = 63'(rnd64());
    d.linvel_a = 63'(rnd64());
    d.angvel_a = 63'(rnd64());
    d.quat_a   = ($urandom_range(1) == 0) ? rnd64() : {48'd0, 16'h4000};
    d.pos_b    = near_vec(d.pos_a);
    d.linvel_b = near_vec(d.linvel_a);
    d.angvel_b = near_vec(d.angvel_a);
    d.quat_b   = near_quat(d.quat_a);
    return d;
  endfunction

  function automatic row_t mk(in_beat_t d, bit typed, out_beat_t e);
    row_t r;
    r.d = d;
    r.typed = typed;
    r.e = e;
    return r;
  endfunction

  task automatic send(in_beat_t d, bit typed, out_beat_t e);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= d;
    use_typed <= typed;
    typed_exp <= e;
    do @(posedge clk); while (in_stall);
  endtask

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      pending_diffs.insert(pending_diffs.size(), use_typed ? typed_exp : pose_diff(in_data));
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_diffs.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: %p", out_data);
      end else begin
        want = pending_diffs.pop_front();
        if (out_data.result_id !== want.result_id ||
            out_data.change_kind !== want.change_kind ||
            out_data.position_distance !== want.position_distance ||
            out_data.height_delta !== want.height_delta ||
            out_data.vertical_speed_delta !== want.vertical_speed_delta ||
            out_data.velocity_distance !== want.velocity_distance ||
            out_data.angle_degrees !== want.angle_degrees ||
            out_data.sleep_changed !== want.sleep_changed) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", want, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    in_beat_t  d;
    out_beat_t e;
    out_beat_t none;
    hold_req = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    use_typed = 1'b0;
    typed_exp = '0;
    send_idle = 0;
    recv_idle = 0;
    none = '0;

    d = '0; d.body_id = 64'hFFFF_FFFF_FFFF_FFFF;
    e = '0; e.change_kind = KIND_NONE;
    rows.insert(rows.size(), mk(d, 1, e));
    d.flags_a = 2'b11;
    e.result_id = d.body_id; e.change_kind = KIND_ONLY_A;
    rows.insert(rows.size(), mk(d, 1, e));
    d.flags_a = 2'b00; d.flags_b = 2'b11; d.body_id = 64'd0;
    e.result_id = 0; e.change_kind = KIND_ONLY_B;
    rows.insert(rows.size(), mk(d, 1, e));
    d = '0; d.body_id = 64'h1234; d.flags_a = 2'b01; d.flags_b = 2'b01;
    d.quat_a = {48'd0, 16'h4000}; d.quat_b = d.quat_a;
    e = '0; e.result_id = 64'h1234; e.change_kind = KIND_EQUAL;
    rows.insert(rows.size(), mk(d, 1, e));
    d.quat_b = '0;
    e.change_kind = KIND_CHANGED; e.angle_degrees = ANGLE_MAX;
    rows.insert(rows.size(), mk(d, 1, e));
    d.quat_b = d.quat_a; d.quat_a = '0;
    rows.insert(rows.size(), mk(d, 1, e));
    d.quat_a = d.quat_b; d.flags_b = 2'b11;
    e.angle_degrees = 0; e.sleep_changed = 1'b1;
    rows.insert(rows.size(), mk(d, 1, e));
    d.flags_b = 2'b01; d.angvel_b = vec3(0, 0, 1);
    e.sleep_changed = 1'b0;
    rows.insert(rows.size(), mk(d, 1, e));
    d.angvel_b = 63'h7FFF_FFFF_FFFF_FFFF; d.angvel_a = d.angvel_b;
    d.pos_a = vec3(-1048576, -1048576, -1048576);
    d.pos_b = vec3(1048575, 1048575, 1048575);
    d.linvel_a = d.pos_b; d.linvel_b = d.pos_a;
    rows.insert(rows.size(), mk(d, 0, none));
    d.pos_a = vec3(0, 1048575, 0); d.pos_b = vec3(0, -1048576, 0);
    rows.insert(rows.size(), mk(d, 0, none));
    d.pos_a = {63{1'b1}}; d.pos_b = d.pos_a; d.linvel_a = '0; d.linvel_b = '0;
    d.quat_b = {48'd0, 16'hC000};
    rows.insert(rows.size(), mk(d, 0, none));
    d.quat_a = 64'h4000_4000_4000_4000; d.quat_b = 64'h4000_4000_4000_4001;
    rows.insert(rows.size(), mk(d, 0, none));
    d.quat_a = {48'd0, 16'h4000}; d.quat_b = {32'd0, 16'h4000, 16'd0};
    rows.insert(rows.size(), mk(d, 0, none));
    d.quat_a = 64'h8000_8000_8000_8000; d.quat_b = 64'h7FFF_7FFF_7FFF_7FFF;
    rows.insert(rows.size(), mk(d, 0, none));
    d.quat_a = 64'h8000_7FFF_8000_7FFF; d.quat_b = 64'h7FFF_8000_0001_FFFF;
    rows.insert(rows.size(), mk(d, 0, none));
    d.quat_a = {48'd0, 16'd1}; d.quat_b = {48'd0, 16'd1};
    d.flags_a = 2'b11; d.flags_b = 2'b11; d.linvel_b = vec3(3, -5, 7);
    rows.insert(rows.size(), mk(d, 0, none));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle = 35;
    recv_idle = 73;
    foreach (rows[i]) send(rows[i].d, rows[i].typed, rows[i].e);
    for (int n = 0; n < 1250; n++) begin
      if (n == 420) begin
        send_idle = 73;
        recv_idle = 35;
      end
      if (n == 840) begin
        send_idle = 0;
        recv_idle = 0;
        hold_req = ~hold_req;
      end
      send(random_beat(), 0, none);
    end
    in_valid <= 1'b0;

    while (pending_diffs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
src/bpd_pkg.sv
src/bpd_front.sv
src/bpd_cell.sv
src/bpd_back.sv
src/body_pose_difference.sv
src/bpd_checker.sv
bench/tb_top.sv
